// ===== design/pcem_pkg.sv =====
// Package for the per-component energy meter: operation codes, stream field
// layout, parameter defaults and the entry-file control struct.
// No dependencies.
package pcem_pkg;

  // operation codes carried in tuser
  localparam logic [1:0] FUNC_ON     = 2'd0;
  localparam logic [1:0] FUNC_OFF    = 2'd1;
  localparam logic [1:0] FUNC_UPDATE = 2'd2;

  localparam int FUNC_W   = 2;
  localparam int COMP_W   = 3;
  localparam int POWER_W  = 16;
  localparam int NOW_W    = 48;
  localparam int ENERGY_W = 64;
  localparam int CTIME_W  = 48;

  // slave tdata: component, power_level, now_ticks (67 bits, padded to 72)
  localparam int COMP_LSB  = 0;
  localparam int POWER_LSB = COMP_LSB + COMP_W;
  localparam int NOW_LSB   = POWER_LSB + POWER_W;
  localparam int S_TDATA_W = 72;

  // master tdata: energy_total, component_time, component_on (113 bits, padded to 120)
  localparam int ENERGY_LSB = 0;
  localparam int CTIME_LSB  = ENERGY_LSB + ENERGY_W;
  localparam int ON_LSB     = CTIME_LSB + CTIME_W;
  localparam int M_TDATA_W  = 120;

  localparam int NUM_COMPONENTS_DEF = 8;
  localparam int TIME_BITS_DEF      = 48;

  // write controls for one entry of the component file
  typedef struct packed {
    logic wr;        // write flag and start time
    logic wr_power;  // write stored power
    logic wr_time;   // write active-time total
    logic flag;      // new active flag
  } ef_ctrl_t;

endpackage

// ===== design/pcem_entry_file.sv =====
// Per-component state file: active flag, start time, power and active time.
// One address per cycle, shared by the read and the write. Depends on pcem_pkg.
module pcem_entry_file #(
  parameter int NUM_COMPONENTS = pcem_pkg::NUM_COMPONENTS_DEF,
  parameter int TIME_BITS      = pcem_pkg::TIME_BITS_DEF,
  parameter int IDX_W          = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic [IDX_W-1:0]              addr,
  input  pcem_pkg::ef_ctrl_t            ctrl,
  input  logic [TIME_BITS-1:0]          wr_start,
  input  logic [pcem_pkg::POWER_W-1:0]  wr_power,
  input  logic [TIME_BITS-1:0]          wr_time,
  output logic                          rd_flag,
  output logic [TIME_BITS-1:0]          rd_start,
  output logic [pcem_pkg::POWER_W-1:0]  rd_power,
  output logic [TIME_BITS-1:0]          rd_time
);
  import pcem_pkg::*;

  logic                 flag_q  [NUM_COMPONENTS];
  logic [TIME_BITS-1:0] start_q [NUM_COMPONENTS];
  logic [POWER_W-1:0]   power_q [NUM_COMPONENTS];
  logic [TIME_BITS-1:0] time_q  [NUM_COMPONENTS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_COMPONENTS; i++) begin
        flag_q[i]  <= 1'b0;
        start_q[i] <= '0;
        power_q[i] <= '0;
        time_q[i]  <= '0;
      end
    end else begin
      if (ctrl.wr) begin
        flag_q[addr]  <= ctrl.flag;
        start_q[addr] <= wr_start;
      end
      if (ctrl.wr_power) begin
        power_q[addr] <= wr_power;
      end
      if (ctrl.wr_time) begin
        time_q[addr] <= wr_time;
      end
    end
  end

  assign rd_flag  = flag_q[addr];
  assign rd_start = start_q[addr];
  assign rd_power = power_q[addr];
  assign rd_time  = time_q[addr];

endmodule

// ===== design/per_component_energy_meter_top.sv =====
// Turn on passes the dispatch and result states; turn off of a valid component passes
// dispatch, read, multiply, accumulate and result; update repeats read, multiply and
// accumulate for every component. The result state holds while the output is stalled.
// A new item is taken only in the idle state, after the last result is loaded; one shared
// read / multiply / saturating-add unit walks the component file. Reset clears every
// component entry and the energy accumulator. Top level of the per-component energy meter:
// sequencer, shared settle unit and output register. Depends on pcem_pkg and pcem_entry_file.
module per_component_energy_meter_top #(
  parameter int NUM_COMPONENTS = pcem_pkg::NUM_COMPONENTS_DEF,
  parameter int TIME_BITS      = pcem_pkg::TIME_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // fields from bit 0: component[2:0], power_level[18:3], now_ticks[66:19], zero pad
  input  logic [pcem_pkg::S_TDATA_W-1:0] s_axis_tdata,
  // fields from bit 0: func[1:0]
  input  logic [pcem_pkg::FUNC_W-1:0]    s_axis_tuser,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // fields from bit 0: energy_total[63:0], component_time[111:64], component_on[112], zero pad
  output logic [pcem_pkg::M_TDATA_W-1:0] m_axis_tdata
);
  import pcem_pkg::*;

  localparam int IDX_W  = (NUM_COMPONENTS > 1) ? $clog2(NUM_COMPONENTS) : 1;
  localparam int PROD_W = TIME_BITS + POWER_W;

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_DISPATCH = 3'd1;
  localparam logic [2:0] ST_READ     = 3'd2;
  localparam logic [2:0] ST_MUL      = 3'd3;
  localparam logic [2:0] ST_ACC      = 3'd4;
  localparam logic [2:0] ST_RESULT   = 3'd5;

  logic [2:0]           state, state_next;
  logic [FUNC_W-1:0]    func;
  logic [IDX_W-1:0]     idx;
  logic                 valid;
  logic [POWER_W-1:0]   power_in;
  logic [TIME_BITS-1:0] now;
  logic [IDX_W-1:0]     walk;
  logic                 act;
  logic [TIME_BITS-1:0] elapsed;
  logic [PROD_W-1:0]    prod;
  logic [ENERGY_W-1:0]  energy_acc, energy_next;

  ef_ctrl_t             ef_ctrl;
  logic [TIME_BITS-1:0] wr_time;
  logic                 rd_flag;
  logic [TIME_BITS-1:0] rd_start;
  logic [POWER_W-1:0]   rd_power;
  logic [TIME_BITS-1:0] rd_time;

  logic [NOW_W-1:0]     in_now;
  logic [31:0]          in_comp32;
  logic                 in_valid;
  logic                 accept, out_load;
  logic                 walk_last;
  logic [ENERGY_W:0]    energy_sum;
  logic [TIME_BITS:0]   time_sum;
  logic [63:0]          time_ext;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign in_now    = s_axis_tdata[NOW_LSB +: NOW_W];
  assign in_comp32 = 32'(s_axis_tdata[COMP_LSB +: COMP_W]);
  assign in_valid  = in_comp32 < 32'(NUM_COMPONENTS);

  assign walk_last = (walk == IDX_W'(NUM_COMPONENTS - 1));
  assign out_load  = (state == ST_RESULT) && (!m_axis_tvalid || m_axis_tready);

  // shared settle unit: saturating accumulate and saturating time total
  assign energy_sum  = {1'b0, energy_acc} + {1'b0, ENERGY_W'(prod)};
  assign energy_next = energy_sum[ENERGY_W] ? {ENERGY_W{1'b1}} : energy_sum[ENERGY_W-1:0];
  assign time_sum    = {1'b0, rd_time} + {1'b0, elapsed};
  assign wr_time     = time_sum[TIME_BITS] ? {TIME_BITS{1'b1}} : time_sum[TIME_BITS-1:0];

  pcem_entry_file #(
    .NUM_COMPONENTS (NUM_COMPONENTS),
    .TIME_BITS      (TIME_BITS),
    .IDX_W          (IDX_W)
  ) u_entry_file (
    .clk      (clk),
    .rst      (rst),
    .addr     (walk),
    .ctrl     (ef_ctrl),
    .wr_start (now),
    .wr_power (power_in),
    .wr_time  (wr_time),
    .rd_flag  (rd_flag),
    .rd_start (rd_start),
    .rd_power (rd_power),
    .rd_time  (rd_time)
  );

  always_comb begin
    state_next = state;
    ef_ctrl    = '0;
    unique case (state)
      ST_IDLE: begin
        if (accept) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (func)
          FUNC_ON: begin
            ef_ctrl.wr       = valid;
            ef_ctrl.wr_power = valid;
            ef_ctrl.flag     = 1'b1;
            state_next       = ST_RESULT;
          end
          FUNC_OFF:    state_next = valid ? ST_READ : ST_RESULT;
          FUNC_UPDATE: state_next = ST_READ;
          default:     state_next = ST_RESULT;
        endcase
      end
      ST_READ: state_next = ST_MUL;
      ST_MUL:  state_next = ST_ACC;
      ST_ACC: begin
        ef_ctrl.wr      = act;
        ef_ctrl.wr_time = act;
        ef_ctrl.flag    = (func != FUNC_OFF);
        state_next      = (func == FUNC_UPDATE && !walk_last) ? ST_READ : ST_RESULT;
      end
      ST_RESULT: begin
        if (out_load) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      walk       <= '0;
      energy_acc <= '0;
    end else begin
      state <= state_next;
      if (accept) begin
        walk <= (s_axis_tuser == FUNC_UPDATE || !in_valid) ? '0 : in_comp32[IDX_W-1:0];
      end
      if (state == ST_ACC) begin
        if (act) energy_acc <= energy_next;
        // advance the walk, or point back at the addressed component (entry 0 if out of range)
        if (func == FUNC_UPDATE && !walk_last) begin
          walk <= walk + 1'b1;
        end else begin
          walk <= valid ? idx : '0;
        end
      end
    end
  end

  // item and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func     <= s_axis_tuser;
      idx      <= in_comp32[IDX_W-1:0];
      valid    <= in_valid;
      power_in <= s_axis_tdata[POWER_LSB +: POWER_W];
      now      <= in_now[TIME_BITS-1:0];
    end
    if (state == ST_READ) begin
      act     <= rd_flag;
      elapsed <= (now >= rd_start) ? (now - rd_start) : '0;
    end
    if (state == ST_MUL) begin
      prod <= PROD_W'(elapsed) * PROD_W'(act ? rd_power : '0);
    end
  end

  assign time_ext = 64'(rd_time);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  // pack component_on, component_time and energy_total from the top bit down
  always_ff @(posedge clk) begin
    if (out_load) begin
      m_axis_tdata <= M_TDATA_W'({valid && rd_flag,
                                  (valid ? time_ext[CTIME_W-1:0] : {CTIME_W{1'b0}}),
                                  energy_acc});
    end
  end

  a_result_from_seq: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_RESULT)
    else $error("result appeared outside the result state");

  a_energy_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> energy_acc >= $past(energy_acc))
    else $error("energy accumulator decreased");

  a_walk_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_ACC) |-> 32'(walk) < 32'(NUM_COMPONENTS))
    else $error("walk index beyond component count");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    (ef_ctrl.wr || ef_ctrl.wr_time || ef_ctrl.wr_power) |->
      (state == ST_DISPATCH || state == ST_ACC))
    else $error("entry write outside dispatch or accumulate");

endmodule
